@@ rtl/ds_twr_distance_core_assert.svh @@
// ---------------------------------------------------------------------------
// DS-TWR distance core: assertion macros
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DS_TWR_DISTANCE_CORE_ASSERT_SVH
`define DS_TWR_DISTANCE_CORE_ASSERT_SVH

// same-cycle implication
`define DSTWR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ds_twr_distance_core check failed");

// next-cycle implication
`define DSTWR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ds_twr_distance_core check failed");

`endif

@@ rtl/dstwr_pkg.sv @@
// ---------------------------------------------------------------------------
// dstwr_pkg
// Shared widths, constants and types of the DS-TWR distance core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dstwr_pkg;

    localparam int TS_W      = 40;
    localparam int DIST_W    = 21;
    localparam int COR_W     = 22;
    localparam int SCALE_W   = 16;
    localparam int OFS_W     = 18;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam int DEN_SHIFT = 28;
    localparam int QUO_W     = 22;
    localparam int MUL_K_W   = 31;
    // metres-per-tick in Q28 times mm-per-metre
    localparam logic [MUL_K_W-1:0] MM_TICK_K = 31'd1259436000;

    localparam logic signed [DIST_W-1:0] WIN_LO = -21'sd100000;
    localparam logic signed [DIST_W-1:0] WIN_HI = 21'sd1000000;
    localparam int unsigned WIN_LO_MAG = 100000;
    localparam int unsigned WIN_HI_MAG = 1000000;
    localparam int COR_LIM = 2000000;

    localparam int CAL_FRAC = 12;
    localparam int CAL_HALF = 2048;
    localparam logic [SCALE_W-1:0]       CAL_SCALE_RST = 16'd4096;
    localparam logic signed [OFS_W-1:0]  CAL_OFS_RST   = 18'sd0;

    localparam int Q_PTR_W = 1;

    typedef enum logic {
        REG_CAL_SCALE  = 1'b0,
        REG_CAL_OFFSET = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [SCALE_W-1:0]      scale;
        logic signed [OFS_W-1:0] offset;
    } cal_t;

endpackage

@@ rtl/dstwr_front.sv @@
// ---------------------------------------------------------------------------
// dstwr_front
// Intake stage: masks timestamps and forms the four wrapping intervals.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dstwr_front #(
    parameter int TIME_BITS = 40
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dstwr_pkg::TS_W-1:0]   poll_tx_time,
    input  logic [dstwr_pkg::TS_W-1:0]   poll_rx_time,
    input  logic [dstwr_pkg::TS_W-1:0]   resp_tx_time,
    input  logic [dstwr_pkg::TS_W-1:0]   resp_rx_time,
    input  logic [dstwr_pkg::TS_W-1:0]   final_tx_time,
    input  logic [dstwr_pkg::TS_W-1:0]   final_rx_time,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [4*TIME_BITS-1:0]       out_word
);

    localparam int TW = TIME_BITS;

    logic          fv_reg;
    logic          fv_next;
    logic [4*TW-1:0] word_reg;
    logic [4*TW-1:0] word_next;
    logic [TW-1:0] round_a;
    logic [TW-1:0] round_b;
    logic [TW-1:0] reply_a;
    logic [TW-1:0] reply_b;

    always_comb
    begin
        round_a   = TW'(resp_rx_time) - TW'(poll_tx_time);
        round_b   = TW'(final_rx_time) - TW'(resp_tx_time);
        reply_a   = TW'(final_tx_time) - TW'(resp_rx_time);
        reply_b   = TW'(resp_tx_time) - TW'(poll_rx_time);
        word_next = {round_a, round_b, reply_a, reply_b};
        in_ready  = !fv_reg || out_ready;
        fv_next   = in_valid || (fv_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = fv_reg;
    assign out_word  = word_reg;

endmodule

@@ rtl/dstwr_queue.sv @@
// ---------------------------------------------------------------------------
// dstwr_queue
// Two-entry word queue between intake and arithmetic back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dstwr_queue #(
    parameter int WORD_W = 160
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [WORD_W-1:0] in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_word
);

    logic [WORD_W-1:0]               ent_reg [2];
    logic [dstwr_pkg::Q_PTR_W-1:0]   wp_reg;
    logic [dstwr_pkg::Q_PTR_W-1:0]   wp_next;
    logic [dstwr_pkg::Q_PTR_W-1:0]   rp_reg;
    logic [dstwr_pkg::Q_PTR_W-1:0]   rp_next;
    logic [dstwr_pkg::Q_PTR_W:0]     cnt_reg;
    logic [dstwr_pkg::Q_PTR_W:0]     cnt_next;
    logic                            push;
    logic                            pop;

    always_comb
    begin
        in_ready  = !cnt_reg[dstwr_pkg::Q_PTR_W];
        out_valid = cnt_reg != '0;
        push      = in_valid && in_ready;
        pop       = out_valid && out_ready;
        wp_next   = push ? wp_reg + 1'b1 : wp_reg;
        rp_next   = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next  = cnt_reg + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
        out_word  = ent_reg[rp_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= in_word;
        end
    end

endmodule

@@ rtl/dstwr_back.sv @@
// ---------------------------------------------------------------------------
// dstwr_back
// Arithmetic pipeline: products, scaling, restoring divider, calibration.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dstwr_back #(
    parameter int TIME_BITS = 40
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [4*TIME_BITS-1:0]                 in_word,
    input  dstwr_pkg::cal_t                        cal,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [dstwr_pkg::DIST_W-1:0]    distance_mm,
    output logic signed [dstwr_pkg::COR_W-1:0]     corrected_mm,
    output logic                                   valid_res
);

    localparam int TW  = TIME_BITS;
    localparam int SW  = TW + 2;
    localparam int DW  = SW + dstwr_pkg::DEN_SHIFT;
    localparam int HL  = (TW + 1) / 2;
    localparam int HH  = TW - HL;
    localparam int PW  = 2 * TW;
    localparam int KW  = dstwr_pkg::MUL_K_W;
    localparam int CHW = 32;
    localparam int NCH = (PW + CHW - 1) / CHW;
    localparam int CPW = CHW + KW;
    localparam int NW  = PW + KW;
    localparam int QB  = dstwr_pkg::QUO_W;
    localparam int HW  = NW + 1 - QB;
    localparam int NST = QB + 9;
    localparam int DSW = dstwr_pkg::DIST_W;
    localparam int CRW = dstwr_pkg::COR_W;
    localparam int PRW = DSW + dstwr_pkg::SCALE_W + 1;
    localparam int RMW = PRW - dstwr_pkg::CAL_FRAC;
    localparam int CW  = RMW + 2;

    logic            en;
    logic [NST-1:0]  vld_reg;
    logic [NST-1:0]  vld_next;

    logic [TW-1:0] ra, rb, pa, pb;
    logic [SW-1:0] sum0;

    // stage 0: partial products
    logic [2*HL-1:0]    a_ll_reg, b_ll_reg;
    logic [HL+HH-1:0]   a_lh_reg, a_hl_reg, b_lh_reg, b_hl_reg;
    logic [2*HH-1:0]    a_hh_reg, b_hh_reg;
    logic [SW-1:0]      s0_sum_reg;
    logic               s0_zero_reg;
    // stage 1: full products
    logic [PW-1:0]      p1_reg, p2_reg;
    logic [PW-1:0]      p1_next, p2_next;
    logic [SW-1:0]      s1_sum_reg;
    logic               s1_zero_reg;
    // stage 2: magnitude of difference
    logic [PW-1:0]      dif_reg;
    logic               s2_neg_reg;
    logic [SW-1:0]      s2_sum_reg;
    logic               s2_zero_reg;
    // stage 3: constant scaling, chunked
    logic [NCH*CHW-1:0] difx;
    logic [CPW-1:0]     cp_reg [NCH];
    logic               s3_neg_reg;
    logic [SW-1:0]      s3_sum_reg;
    logic               s3_zero_reg;
    // stage 4: scaled numerator
    logic [NW-1:0]      num_next;
    logic [NW-1:0]      num_reg;
    logic               s4_neg_reg;
    logic [SW-1:0]      s4_sum_reg;
    logic               s4_zero_reg;
    // stage 5 and divider steps
    logic [NW:0]        n2;
    logic [HW-1:0]      n2_hi;
    logic [DW-1:0]      den5;
    logic               ovf5;
    logic [DW-1:0]      dv_rm_reg   [QB+1];
    logic [QB-1:0]      dv_lq_reg   [QB+1];
    logic [SW-1:0]      dv_sum_reg  [QB+1];
    logic               dv_zero_reg [QB+1];
    logic               dv_neg_reg  [QB+1];
    logic               dv_ovf_reg  [QB+1];
    logic [DW:0]        dv_trial [QB];
    logic [DW:0]        dv_dext  [QB];
    logic [DW:0]        dv_diff  [QB];
    logic [QB-1:0]      dv_take;
    // rounding and window
    logic [QB:0]        q1;
    logic [QB-1:0]      mag;
    logic signed [DSW-1:0] f_dist_next;
    logic               f_valid_next;
    logic signed [DSW-1:0] f_dist_reg;
    logic               f_valid_reg;
    logic               f_zero_reg;
    // calibration gain
    logic signed [PRW-1:0] p_prod_reg;
    logic signed [DSW-1:0] p_dist_reg;
    logic               p_valid_reg;
    logic               p_zero_reg;
    // calibration offset and output
    logic               pneg;
    logic [PRW-1:0]     pabs;
    logic [PRW-1:0]     rsum;
    logic [RMW-1:0]     rmag;
    logic signed [CW-1:0] cval;
    logic signed [CW-1:0] csum;
    logic signed [CRW-1:0] cor_next;
    logic signed [DSW-1:0] dist_out_reg;
    logic signed [CRW-1:0] cor_out_reg;
    logic               valid_out_reg;

    assign en        = !vld_reg[NST-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NST-1];
    assign vld_next  = {vld_reg[NST-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        ra   = in_word[4*TW-1 -: TW];
        rb   = in_word[3*TW-1 -: TW];
        pa   = in_word[2*TW-1 -: TW];
        pb   = in_word[TW-1:0];
        sum0 = SW'(ra) + SW'(rb) + SW'(pa) + SW'(pb);

        p1_next = PW'(a_ll_reg) + ((PW'(a_lh_reg) + PW'(a_hl_reg)) << HL)
                + (PW'(a_hh_reg) << (2 * HL));
        p2_next = PW'(b_ll_reg) + ((PW'(b_lh_reg) + PW'(b_hl_reg)) << HL)
                + (PW'(b_hh_reg) << (2 * HL));

        difx = (NCH * CHW)'(dif_reg);

        num_next = '0;
        for (int k = 0; k < NCH; k++)
        begin
            num_next = num_next + (NW'(cp_reg[k]) << (CHW * k));
        end

        n2    = {num_reg, 1'b0};
        n2_hi = n2[NW:QB];
        den5  = {s4_sum_reg, {dstwr_pkg::DEN_SHIFT{1'b0}}};
        ovf5  = n2_hi >= HW'(den5);

        for (int i = 0; i < QB; i++)
        begin
            dv_dext[i]  = {1'b0, dv_sum_reg[i], {dstwr_pkg::DEN_SHIFT{1'b0}}};
            dv_trial[i] = {dv_rm_reg[i], dv_lq_reg[i][QB-1]};
            dv_take[i]  = dv_trial[i] >= dv_dext[i];
            dv_diff[i]  = dv_trial[i] - dv_dext[i];
        end

        // half away from zero: (floor(2n/d) + 1) / 2
        q1  = {1'b0, dv_lq_reg[QB]} + (QB + 1)'(1);
        mag = q1[QB:1];
        if (dv_zero_reg[QB])
        begin
            f_dist_next  = '0;
            f_valid_next = 1'b0;
        end
        else if (dv_neg_reg[QB])
        begin
            f_valid_next = !dv_ovf_reg[QB] && (mag < QB'(dstwr_pkg::WIN_LO_MAG));
            if (dv_ovf_reg[QB] || (mag > QB'(dstwr_pkg::WIN_LO_MAG)))
            begin
                f_dist_next = dstwr_pkg::WIN_LO;
            end
            else
            begin
                f_dist_next = DSW'(0) - DSW'(mag);
            end
        end
        else
        begin
            f_valid_next = !dv_ovf_reg[QB] && (mag < QB'(dstwr_pkg::WIN_HI_MAG));
            if (dv_ovf_reg[QB] || (mag > QB'(dstwr_pkg::WIN_HI_MAG)))
            begin
                f_dist_next = dstwr_pkg::WIN_HI;
            end
            else
            begin
                f_dist_next = DSW'(mag);
            end
        end

        pneg = p_prod_reg[PRW-1];
        pabs = pneg ? PRW'(-p_prod_reg) : PRW'(p_prod_reg);
        rsum = pabs + PRW'(dstwr_pkg::CAL_HALF);
        rmag = rsum[PRW-1:dstwr_pkg::CAL_FRAC];
        cval = pneg ? -$signed(CW'(rmag)) : $signed(CW'(rmag));
        csum = cval + CW'(cal.offset);
        if (p_zero_reg)
        begin
            cor_next = '0;
        end
        else if (csum > dstwr_pkg::COR_LIM)
        begin
            cor_next = CRW'(dstwr_pkg::COR_LIM);
        end
        else if (csum < -dstwr_pkg::COR_LIM)
        begin
            cor_next = CRW'(-dstwr_pkg::COR_LIM);
        end
        else
        begin
            cor_next = CRW'(csum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ll_reg    <= ra[HL-1:0] * rb[HL-1:0];
            a_lh_reg    <= ra[HL-1:0] * rb[TW-1:HL];
            a_hl_reg    <= ra[TW-1:HL] * rb[HL-1:0];
            a_hh_reg    <= ra[TW-1:HL] * rb[TW-1:HL];
            b_ll_reg    <= pa[HL-1:0] * pb[HL-1:0];
            b_lh_reg    <= pa[HL-1:0] * pb[TW-1:HL];
            b_hl_reg    <= pa[TW-1:HL] * pb[HL-1:0];
            b_hh_reg    <= pa[TW-1:HL] * pb[TW-1:HL];
            s0_sum_reg  <= sum0;
            s0_zero_reg <= sum0 == '0;

            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
            s1_sum_reg  <= s0_sum_reg;
            s1_zero_reg <= s0_zero_reg;

            s2_neg_reg  <= p2_reg > p1_reg;
            dif_reg     <= (p2_reg > p1_reg) ? p2_reg - p1_reg : p1_reg - p2_reg;
            s2_sum_reg  <= s1_sum_reg;
            s2_zero_reg <= s1_zero_reg;

            for (int k = 0; k < NCH; k++)
            begin
                cp_reg[k] <= difx[CHW*k +: CHW] * dstwr_pkg::MM_TICK_K;
            end
            s3_neg_reg  <= s2_neg_reg;
            s3_sum_reg  <= s2_sum_reg;
            s3_zero_reg <= s2_zero_reg;

            num_reg     <= num_next;
            s4_neg_reg  <= s3_neg_reg;
            s4_sum_reg  <= s3_sum_reg;
            s4_zero_reg <= s3_zero_reg;

            dv_rm_reg[0]   <= n2_hi[DW-1:0];
            dv_lq_reg[0]   <= n2[QB-1:0];
            dv_sum_reg[0]  <= s4_sum_reg;
            dv_zero_reg[0] <= s4_zero_reg;
            dv_neg_reg[0]  <= s4_neg_reg;
            dv_ovf_reg[0]  <= ovf5;
            for (int i = 0; i < QB; i++)
            begin
                dv_rm_reg[i+1]   <= dv_take[i] ? dv_diff[i][DW-1:0] : dv_trial[i][DW-1:0];
                dv_lq_reg[i+1]   <= {dv_lq_reg[i][QB-2:0], dv_take[i]};
                dv_sum_reg[i+1]  <= dv_sum_reg[i];
                dv_zero_reg[i+1] <= dv_zero_reg[i];
                dv_neg_reg[i+1]  <= dv_neg_reg[i];
                dv_ovf_reg[i+1]  <= dv_ovf_reg[i];
            end

            f_dist_reg  <= f_dist_next;
            f_valid_reg <= f_valid_next;
            f_zero_reg  <= dv_zero_reg[QB];

            p_prod_reg  <= f_dist_reg * $signed({1'b0, cal.scale});
            p_dist_reg  <= f_dist_reg;
            p_valid_reg <= f_valid_reg;
            p_zero_reg  <= f_zero_reg;

            dist_out_reg  <= p_dist_reg;
            cor_out_reg   <= cor_next;
            valid_out_reg <= p_valid_reg;
        end
    end

    assign distance_mm  = dist_out_reg;
    assign corrected_mm = cor_out_reg;
    assign valid_res    = valid_out_reg;

endmodule

@@ rtl/ds_twr_distance_core.sv @@
// ---------------------------------------------------------------------------
// ds_twr_distance_core
// Double-sided two-way ranging distance with calibration, APB registers.
// ---------------------------------------------------------------------------
// Path from input word accept to out_valid: intake register, queue entry,
//   31 back-end stages of which 22 are restoring divider steps.
// Throughput: one word per cycle; the back end stalls as a whole on out_ready.
// Reset: handshake state cleared, cal_scale 1.0 (4096), cal_offset_mm 0.
`timescale 1ns / 1ps

module ds_twr_distance_core #(
    parameter int TIME_BITS = 40
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [dstwr_pkg::APB_AW-1:0]          paddr,
    input  logic [dstwr_pkg::APB_DW-1:0]          pwdata,
    output logic [dstwr_pkg::APB_DW-1:0]          prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [dstwr_pkg::TS_W-1:0]            poll_tx_time,
    input  logic [dstwr_pkg::TS_W-1:0]            poll_rx_time,
    input  logic [dstwr_pkg::TS_W-1:0]            resp_tx_time,
    input  logic [dstwr_pkg::TS_W-1:0]            resp_rx_time,
    input  logic [dstwr_pkg::TS_W-1:0]            final_tx_time,
    input  logic [dstwr_pkg::TS_W-1:0]            final_rx_time,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [dstwr_pkg::DIST_W-1:0]   distance_mm,
    output logic signed [dstwr_pkg::COR_W-1:0]    corrected_mm,
    output logic                                  valid_res
);

    localparam int WW = 4 * TIME_BITS;

    dstwr_pkg::cal_t        cal_reg;
    dstwr_pkg::cal_t        cal_next;
    dstwr_pkg::reg_idx_t    reg_idx;
    logic                   wr_en;
    logic                   fr_valid;
    logic                   fr_ready;
    logic [WW-1:0]          fr_word;
    logic                   bk_valid;
    logic                   bk_ready;
    logic [WW-1:0]          bk_word;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = dstwr_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        cal_next = cal_reg;
        prdata   = '0;
        unique case (reg_idx)
            dstwr_pkg::REG_CAL_SCALE:
            begin
                prdata = dstwr_pkg::APB_DW'(cal_reg.scale);
                if (wr_en)
                begin
                    cal_next.scale = pwdata[dstwr_pkg::SCALE_W-1:0];
                end
            end
            dstwr_pkg::REG_CAL_OFFSET:
            begin
                prdata = dstwr_pkg::APB_DW'(cal_reg.offset);
                if (wr_en)
                begin
                    cal_next.offset = $signed(pwdata[dstwr_pkg::OFS_W-1:0]);
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg.scale  <= dstwr_pkg::CAL_SCALE_RST;
            cal_reg.offset <= dstwr_pkg::CAL_OFS_RST;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    dstwr_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .poll_tx_time  (poll_tx_time),
        .poll_rx_time  (poll_rx_time),
        .resp_tx_time  (resp_tx_time),
        .resp_rx_time  (resp_rx_time),
        .final_tx_time (final_tx_time),
        .final_rx_time (final_rx_time),
        .out_valid     (fr_valid),
        .out_ready     (fr_ready),
        .out_word      (fr_word)
    );

    dstwr_queue #(
        .WORD_W (WW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_word   (fr_word),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_word  (bk_word)
    );

    dstwr_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (bk_valid),
        .in_ready     (bk_ready),
        .in_word      (bk_word),
        .cal          (cal_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .distance_mm  (distance_mm),
        .corrected_mm (corrected_mm),
        .valid_res    (valid_res)
    );

endmodule

@@ rtl/ds_twr_distance_core_chk.sv @@
// ---------------------------------------------------------------------------
// ds_twr_distance_core_chk
// Port-level checks on the result channel and the APB port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ds_twr_distance_core_assert.svh"

module ds_twr_distance_core_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                pready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [dstwr_pkg::DIST_W-1:0] distance_mm,
    input logic signed [dstwr_pkg::COR_W-1:0]  corrected_mm,
    input logic                                valid_res
);

    `DSTWR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(distance_mm) && $stable(corrected_mm) && $stable(valid_res))
    `DSTWR_ASSERT_IMP(a_dist_window, out_valid, distance_mm >= dstwr_pkg::WIN_LO && distance_mm <= dstwr_pkg::WIN_HI)
    `DSTWR_ASSERT_IMP(a_valid_inside, out_valid && valid_res, distance_mm != dstwr_pkg::WIN_LO && distance_mm != dstwr_pkg::WIN_HI)
    `DSTWR_ASSERT_IMP(a_zero_den, out_valid && !valid_res && distance_mm == '0, corrected_mm == '0)
    `DSTWR_ASSERT_IMP(a_apb_ready, 1'b1, pready)

endmodule

bind ds_twr_distance_core ds_twr_distance_core_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .distance_mm  (distance_mm),
    .corrected_mm (corrected_mm),
    .valid_res    (valid_res)
);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// DS-TWR distance core testbench
// Streams six-timestamp ranging exchanges through the core under several
// calibration settings, predicts distance, corrected distance and validity
// in exact wide integer arithmetic, and checks every output word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam longint unsigned QUO_CAP    = 64'hFFFF_FFFF;
    localparam logic [191:0]    TICK_MM_K  = 192'd1259436000;
    localparam int              HOLD_LONG  = 400;
    localparam int              DRAIN_WAIT = 40;
    localparam longint          CYCLE_MAX  = 2000000;

    typedef struct {
        logic [dstwr_pkg::TS_W-1:0] poll_tx;
        logic [dstwr_pkg::TS_W-1:0] poll_rx;
        logic [dstwr_pkg::TS_W-1:0] resp_tx;
        logic [dstwr_pkg::TS_W-1:0] resp_rx;
        logic [dstwr_pkg::TS_W-1:0] final_tx;
        logic [dstwr_pkg::TS_W-1:0] final_rx;
    } exchange_t;

    typedef struct {
        logic signed [dstwr_pkg::DIST_W-1:0] dist_mm;
        logic signed [dstwr_pkg::COR_W-1:0]  cor;
        logic                                ok;
    } range_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [dstwr_pkg::APB_AW-1:0] paddr = '0;
    logic [dstwr_pkg::APB_DW-1:0] pwdata = '0;
    logic [dstwr_pkg::APB_DW-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [dstwr_pkg::TS_W-1:0] poll_tx_time = '0;
    logic [dstwr_pkg::TS_W-1:0] poll_rx_time = '0;
    logic [dstwr_pkg::TS_W-1:0] resp_tx_time = '0;
    logic [dstwr_pkg::TS_W-1:0] resp_rx_time = '0;
    logic [dstwr_pkg::TS_W-1:0] final_tx_time = '0;
    logic [dstwr_pkg::TS_W-1:0] final_rx_time = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [dstwr_pkg::DIST_W-1:0] distance_mm;
    logic signed [dstwr_pkg::COR_W-1:0]  corrected_mm;
    logic valid_res;

    ds_twr_distance_core u_dut (.*);

    exchange_t pending_words[$];
    range_t    expected_ranges[$];
    logic [dstwr_pkg::SCALE_W-1:0] cal_gain = dstwr_pkg::CAL_SCALE_RST;
    longint             cal_ofs  = 0;
    bit  quiet_run = 1'b0;
    bit  hold_start = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  mismatches = 0;
    longint cycles = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic range_t predict_range(exchange_t x);
        logic [dstwr_pkg::TS_W-1:0] ra, rb, da, db;
        logic [191:0] den, p1, p2, num, quo, rem;
        bit neg;
        longint mm, clamped, prod, cr, cor;
        range_t r;
        ra = x.resp_rx - x.poll_tx;
        rb = x.final_rx - x.resp_tx;
        da = x.final_tx - x.resp_rx;
        db = x.resp_tx - x.poll_rx;
        den = 192'(ra) + 192'(rb) + 192'(da) + 192'(db);
        r.dist_mm = '0;
        r.cor = '0;
        r.ok = 1'b0;
        if (den == 0)
            return r;
        p1 = 192'(ra) * 192'(rb);
        p2 = 192'(da) * 192'(db);
        neg = p2 > p1;
        num = (neg ? p2 - p1 : p1 - p2) * TICK_MM_K;
        den = den << dstwr_pkg::DEN_SHIFT;
        quo = num / den;
        rem = num % den;
        if (quo > 192'(QUO_CAP))
            quo = 192'(QUO_CAP) + 1;
        if ((rem << 1) >= den)
            quo = quo + 1;
        mm = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        r.ok = (mm > -100000) && (mm < 1000000);
        clamped = mm < -100000 ? -100000 : (mm > 1000000 ? 1000000 : mm);
        prod = clamped * longint'(cal_gain);
        cr = prod >= 0 ? ((prod + dstwr_pkg::CAL_HALF) >>> dstwr_pkg::CAL_FRAC)
                       : -((-prod + dstwr_pkg::CAL_HALF) >>> dstwr_pkg::CAL_FRAC);
        cor = cr + cal_ofs;
        if (cor > dstwr_pkg::COR_LIM)
            cor = dstwr_pkg::COR_LIM;
        if (cor < -dstwr_pkg::COR_LIM)
            cor = -dstwr_pkg::COR_LIM;
        r.dist_mm = clamped[dstwr_pkg::DIST_W-1:0];
        r.cor = cor[dstwr_pkg::COR_W-1:0];
        return r;
    endfunction

    // well-formed exchange: common start, responder clock offset, flight time
    function automatic exchange_t make_exchange(longint tof, longint da, longint db);
        exchange_t x;
        logic [dstwr_pkg::TS_W-1:0] t0, ofs;
        t0 = dstwr_pkg::TS_W'({$urandom, $urandom});
        ofs = dstwr_pkg::TS_W'({$urandom, $urandom});
        x.poll_tx = t0;
        x.poll_rx = t0 + ofs + dstwr_pkg::TS_W'(tof);
        x.resp_tx = x.poll_rx + dstwr_pkg::TS_W'(db);
        x.resp_rx = t0 + dstwr_pkg::TS_W'(2 * tof + db);
        x.final_tx = x.resp_rx + dstwr_pkg::TS_W'(da);
        x.final_rx = x.resp_tx + dstwr_pkg::TS_W'(da + 2 * tof);
        return x;
    endfunction

    function automatic exchange_t noise_exchange();
        exchange_t x;
        x.poll_tx = dstwr_pkg::TS_W'({$urandom, $urandom});
        x.poll_rx = dstwr_pkg::TS_W'({$urandom, $urandom});
        x.resp_tx = dstwr_pkg::TS_W'({$urandom, $urandom});
        x.resp_rx = dstwr_pkg::TS_W'({$urandom, $urandom});
        x.final_tx = dstwr_pkg::TS_W'({$urandom, $urandom});
        x.final_rx = dstwr_pkg::TS_W'({$urandom, $urandom});
        return x;
    endfunction

    function automatic exchange_t random_exchange();
        int pick;
        longint tof;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return noise_exchange();
        if (pick < 4)
            tof = longint'($urandom_range(0, 260000)) - 30000;
        else
            tof = $urandom_range(0, 40000);
        if (pick == 9)
            return make_exchange(tof, $urandom_range(0, 50), $urandom_range(0, 50));
        return make_exchange(tof, $urandom_range(1000, 32'h3FFF_FFFF),
                             $urandom_range(1000, 32'h3FFF_FFFF));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        exchange_t x;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                x.poll_tx = poll_tx_time;
                x.poll_rx = poll_rx_time;
                x.resp_tx = resp_tx_time;
                x.resp_rx = resp_rx_time;
                x.final_tx = final_tx_time;
                x.final_rx = final_rx_time;
                expected_ranges.push_back(predict_range(x));
            end
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() == 0)
                in_valid <= 1'b0;
            else if (!quiet_run && $urandom_range(0, 11) == 0)
            begin
                send_gap <= $urandom_range(1, 19) - 1;
                in_valid <= 1'b0;
            end
            else
            begin
                x = pending_words.pop_front();
                poll_tx_time <= x.poll_tx;
                poll_rx_time <= x.poll_rx;
                resp_tx_time <= x.resp_tx;
                resp_rx_time <= x.resp_rx;
                final_tx_time <= x.final_tx;
                final_rx_time <= x.final_rx;
                in_valid <= 1'b1;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        range_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_ranges.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output word: dist %0d cor %0d ok %0b",
                                 distance_mm, corrected_mm, valid_res);
                end
                else
                begin
                    e = expected_ranges.pop_front();
                    if (e.dist_mm !== distance_mm || e.cor !== corrected_mm
                        || e.ok !== valid_res)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp dist %0d cor %0d ok %0b, got %0d %0d %0b",
                                     e.dist_mm, e.cor, e.ok, distance_mm, corrected_mm,
                                     valid_res);
                    end
                end
            end
            if (hold_start && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_LONG;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!quiet_run && $urandom_range(0, 9) == 0)
            begin
                recv_gap <= $urandom_range(1, 19) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic reg_write(dstwr_pkg::reg_idx_t idx, logic [dstwr_pkg::APB_DW-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= dstwr_pkg::APB_AW'(4 * int'(idx));
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == dstwr_pkg::REG_CAL_SCALE)
            cal_gain = value[dstwr_pkg::SCALE_W-1:0];
        else
            cal_ofs = longint'($signed(value[dstwr_pkg::OFS_W-1:0]));
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_ranges.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic run_phase(logic [dstwr_pkg::SCALE_W-1:0] gain, int ofs, int count);
        reg_write(dstwr_pkg::REG_CAL_SCALE, dstwr_pkg::APB_DW'(gain));
        reg_write(dstwr_pkg::REG_CAL_OFFSET, dstwr_pkg::APB_DW'(ofs));
        for (int i = 0; i < count; i++)
            pending_words.push_back(random_exchange());
        wait_drained();
    endtask

    initial
    begin
        exchange_t x;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset calibration, zero denominator, extremes, window edges
        x = '{default: '0};
        pending_words.push_back(x);
        x = '{default: '1};
        pending_words.push_back(x);
        x = '{poll_tx: '1, poll_rx: '0, resp_tx: '1, resp_rx: '0, final_tx: '1, final_rx: '0};
        pending_words.push_back(x);
        x = '{poll_tx: '0, poll_rx: '1, resp_tx: '0, resp_rx: '1, final_tx: '0, final_rx: '1};
        pending_words.push_back(x);
        pending_words.push_back(make_exchange(0, 100000, 100000));
        pending_words.push_back(make_exchange(1, 1, 1));
        pending_words.push_back(make_exchange(0, 0, 0));
        pending_words.push_back(make_exchange(21314, 500000, 700000));
        pending_words.push_back(make_exchange(213139, 500000, 700000));
        pending_words.push_back(make_exchange(213140, 500000, 700000));
        pending_words.push_back(make_exchange(-21313, 500000, 700000));
        pending_words.push_back(make_exchange(-21314, 500000, 700000));
        pending_words.push_back(make_exchange(-40000, 900000, 300000));
        pending_words.push_back(make_exchange(5000, 32'h7FFF_FFFF, 1));
        pending_words.push_back(make_exchange(1000000, 10, 10));
        pending_words.push_back(make_exchange(7, 40'h7F_FFFF_FFFF, 40'h7F_FFFF_FFFF));
        for (int i = 0; i < 4; i++)
            pending_words.push_back(noise_exchange());
        wait_drained();

        // gain at maximum and a positive offset, to reach corrected saturation
        reg_write(dstwr_pkg::REG_CAL_SCALE, dstwr_pkg::APB_DW'(16'hFFFF));
        reg_write(dstwr_pkg::REG_CAL_OFFSET, dstwr_pkg::APB_DW'(100000));
        pending_words.push_back(make_exchange(213140, 500000, 700000));
        pending_words.push_back(make_exchange(-40000, 500000, 700000));
        pending_words.push_back(make_exchange(3000, 500000, 700000));
        wait_drained();

        // long receiver hold while the sender keeps offering
        for (int i = 0; i < 120; i++)
            pending_words.push_back(random_exchange());
        hold_start = 1'b1;
        wait_drained();

        run_phase(16'd0, -100000, 100);
        run_phase(16'd4096, 0, 120);
        run_phase(16'hFFFF, -100000, 100);
        run_phase(16'($urandom), $urandom_range(0, 200000) - 100000, 120);
        run_phase(16'd1, 100000, 80);
        quiet_run = 1'b1;
        run_phase(16'($urandom), $urandom_range(0, 200000) - 100000, 100);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
